// ----- design/dltq_pkg.sv -----
// Shared types and constants of the delta-list timer queue.
package dltq_pkg;

  localparam int TAG_W          = 16;
  localparam int DELAY_IN_W     = 16;
  localparam int SLOTS_DEF      = 16;
  localparam int DELAY_BITS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int FIRED_W        = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    REQ_SCHEDULE = 1'b0,
    REQ_TICK     = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_IDLE     = 2'd3
  } result_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_WREQ,
    ST_WCHK,
    ST_INSERT,
    ST_LINK,
    ST_RES,
    ST_TREAD,
    ST_TCHK,
    ST_FLUSH
  } state_t;

endpackage

// ----- design/dltq_if.sv -----
// Valid/ready channel interfaces for requests and results of the timer queue.
interface dltq_req_if;
  logic                          valid;
  logic                          ready;
  dltq_pkg::req_type_t           req_type;
  logic [dltq_pkg::TAG_W-1:0]      callback_tag;
  logic [dltq_pkg::TAG_W-1:0]      argument_tag;
  logic [dltq_pkg::DELAY_IN_W-1:0] delay_ticks;

  modport source (output valid, req_type, callback_tag, argument_tag, delay_ticks,
                  input ready);
  modport sink (input valid, req_type, callback_tag, argument_tag, delay_ticks,
                output ready);
endinterface

interface dltq_res_if;
  logic                       valid;
  logic                       ready;
  dltq_pkg::result_kind_t     result_kind;
  logic [dltq_pkg::TAG_W-1:0] fired_callback;
  logic [dltq_pkg::TAG_W-1:0] fired_argument;
  logic                       last_of_run;

  modport source (output valid, result_kind, fired_callback, fired_argument, last_of_run,
                  input ready);
  modport sink (input valid, result_kind, fired_callback, fired_argument, last_of_run,
                output ready);
endinterface

// ----- design/delta_list_timer_queue.sv -----
// Delta-list timer queue: slot pool, list walk sequencer and result register.
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | req_type, callback_tag, argument_tag, delay_ticks
//  res     | out | result_kind, fired_callback, fired_argument, last_of_run
//
// Schedule: scan from slot 0 for the first free slot, walk the list past each entry
// that expires no later than the new timer, then insert and link; a full pool is
// rejected. The single read port of the slot memory sets the walk pace.
// Tick: decrement a nonzero head delay, then fire due head entries (up to MAX_RESULTS).
// Reset clears the state, busy bits, head and tick flags; slot memory needs no clearing.
// A full result register stalls the sequencer; req is taken only when idle.
module delta_list_timer_queue #(
  parameter int SLOTS      = dltq_pkg::SLOTS_DEF,
  parameter int DELAY_BITS = dltq_pkg::DELAY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dltq_req_if.sink   req,
  dltq_res_if.source res
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW = DELAY_BITS;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [47:0] DMAX = (48'(1) << DW) - 48'(1);

  // slot memory
  logic [dltq_pkg::TAG_W-1:0] mem_cb    [SLOTS];
  logic [dltq_pkg::TAG_W-1:0] mem_arg   [SLOTS];
  logic [DW-1:0]              mem_delta [SLOTS];
  logic [LW-1:0]              mem_link  [SLOTS];

  logic [dltq_pkg::TAG_W-1:0] rd_cb, rd_arg;
  logic [DW-1:0]              rd_delta;
  logic [LW-1:0]              rd_link;

  dltq_pkg::state_t state, state_next;

  logic [dltq_pkg::TAG_W-1:0] req_cb, req_arg;
  logic [DW-1:0]              req_ms;
  logic [IW-1:0]              slot;
  logic [LW-1:0]              scan, cur, prev, head;
  logic [DW-1:0]              time_acc, cur_delta;
  logic [SLOTS-1:0]           busy;
  logic                       first, have_pend;
  logic [dltq_pkg::TAG_W-1:0] pend_cb, pend_arg;
  logic [dltq_pkg::FIRED_W-1:0] fired_n;
  dltq_pkg::result_kind_t     res_kind;

  // control
  logic                       accept, out_free;
  logic [47:0]                dly_wide;
  logic [DW-1:0]              ms_sat;
  logic [DW:0]                walk_sum;
  logic                       walk_ok;
  logic [DW-1:0]              new_delta;
  logic                       tk_dec, tk_fire;
  logic [DW-1:0]              tk_delta;
  logic                       last_fire;

  logic [IW-1:0]              rd_addr;
  logic                       slot_we;
  logic                       d_we, l_we;
  logic [IW-1:0]              d_wa, l_wa;
  logic [DW-1:0]              d_wd;
  logic [LW-1:0]              l_wd;
  logic                       emit, emit_last;
  dltq_pkg::result_kind_t     emit_kind;
  logic [dltq_pkg::TAG_W-1:0] emit_cb, emit_arg;

  assign req.ready = (state == dltq_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !res.valid || res.ready;

  assign dly_wide  = 48'(req.delay_ticks);
  assign ms_sat    = (dly_wide > DMAX) ? DMAX[DW-1:0] : dly_wide[DW-1:0];

  assign walk_sum  = {1'b0, rd_delta} + {1'b0, time_acc};
  assign walk_ok   = (walk_sum <= {1'b0, req_ms});
  assign new_delta = req_ms - time_acc;

  assign tk_dec    = first && (rd_delta != '0);
  assign tk_delta  = tk_dec ? (rd_delta - DW'(1)) : rd_delta;
  assign tk_fire   = (tk_delta == '0);
  assign last_fire = (rd_link == NIL) ||
                     (fired_n == dltq_pkg::FIRED_W'(dltq_pkg::MAX_RESULTS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dltq_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.req_type == dltq_pkg::REQ_TICK) begin
            state_next = (head == NIL) ? dltq_pkg::ST_RES : dltq_pkg::ST_TREAD;
          end else begin
            state_next = dltq_pkg::ST_FIND;
          end
        end
      end
      dltq_pkg::ST_FIND: begin
        if (scan == NIL) begin
          state_next = dltq_pkg::ST_RES;
        end else if (!busy[scan[IW-1:0]]) begin
          state_next = dltq_pkg::ST_WREQ;
        end
      end
      dltq_pkg::ST_WREQ:   state_next = (cur == NIL) ? dltq_pkg::ST_INSERT : dltq_pkg::ST_WCHK;
      dltq_pkg::ST_WCHK:   state_next = walk_ok ? dltq_pkg::ST_WREQ : dltq_pkg::ST_INSERT;
      dltq_pkg::ST_INSERT: state_next = dltq_pkg::ST_LINK;
      dltq_pkg::ST_LINK:   state_next = dltq_pkg::ST_RES;
      dltq_pkg::ST_RES: begin
        if (out_free) state_next = dltq_pkg::ST_IDLE;
      end
      dltq_pkg::ST_TREAD:  state_next = dltq_pkg::ST_TCHK;
      dltq_pkg::ST_TCHK: begin
        if (out_free) begin
          if (tk_fire) begin
            state_next = last_fire ? dltq_pkg::ST_FLUSH : dltq_pkg::ST_TREAD;
          end else begin
            state_next = dltq_pkg::ST_IDLE;
          end
        end
      end
      dltq_pkg::ST_FLUSH: begin
        if (out_free) state_next = dltq_pkg::ST_IDLE;
      end
      default: state_next = dltq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_addr   = cur[IW-1:0];
    slot_we   = 1'b0;
    d_we      = 1'b0;
    d_wa      = slot;
    d_wd      = new_delta;
    l_we      = 1'b0;
    l_wa      = slot;
    l_wd      = cur;
    emit      = 1'b0;
    emit_kind = res_kind;
    emit_cb   = '0;
    emit_arg  = '0;
    emit_last = 1'b1;
    case (state)
      dltq_pkg::ST_INSERT: begin
        slot_we = 1'b1;
        d_we    = 1'b1;
        l_we    = 1'b1;
      end
      dltq_pkg::ST_LINK: begin
        d_we = (cur != NIL);
        d_wa = cur[IW-1:0];
        d_wd = cur_delta - new_delta;
        l_we = (prev != NIL);
        l_wa = prev[IW-1:0];
        l_wd = LW'(slot);
      end
      dltq_pkg::ST_RES: begin
        emit = out_free;
      end
      dltq_pkg::ST_TREAD: begin
        rd_addr = head[IW-1:0];
      end
      dltq_pkg::ST_TCHK: begin
        rd_addr = head[IW-1:0];
        d_we    = out_free && tk_dec;
        d_wa    = head[IW-1:0];
        d_wd    = tk_delta;
        emit    = out_free && (have_pend || !tk_fire);
        if (have_pend) begin
          emit_kind = dltq_pkg::KIND_FIRED;
          emit_cb   = pend_cb;
          emit_arg  = pend_arg;
          emit_last = !tk_fire;
        end else begin
          emit_kind = dltq_pkg::KIND_IDLE;
        end
      end
      dltq_pkg::ST_FLUSH: begin
        emit      = out_free;
        emit_kind = dltq_pkg::KIND_FIRED;
        emit_cb   = pend_cb;
        emit_arg  = pend_arg;
      end
      default: begin
      end
    endcase
  end

  // slot memory ports
  always_ff @(posedge clk) begin
    rd_cb    <= mem_cb[rd_addr];
    rd_arg   <= mem_arg[rd_addr];
    rd_delta <= mem_delta[rd_addr];
    rd_link  <= mem_link[rd_addr];
    if (slot_we) begin
      mem_cb[slot]  <= req_cb;
      mem_arg[slot] <= req_arg;
    end
    if (d_we) mem_delta[d_wa] <= d_wd;
    if (l_we) mem_link[l_wa]  <= l_wd;
  end

  // sequencer state and list control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dltq_pkg::ST_IDLE;
      head      <= NIL;
      busy      <= '0;
      first     <= 1'b0;
      have_pend <= 1'b0;
      fired_n   <= '0;
    end else begin
      state <= state_next;
      case (state)
        dltq_pkg::ST_IDLE: begin
          if (accept) begin
            req_cb    <= req.callback_tag;
            req_arg   <= req.argument_tag;
            req_ms    <= ms_sat;
            scan      <= '0;
            first     <= 1'b1;
            have_pend <= 1'b0;
            fired_n   <= '0;
            res_kind  <= dltq_pkg::KIND_IDLE;
          end
        end
        dltq_pkg::ST_FIND: begin
          if (scan == NIL) begin
            res_kind <= dltq_pkg::KIND_REJECTED;
          end else if (!busy[scan[IW-1:0]]) begin
            slot     <= scan[IW-1:0];
            cur      <= head;
            prev     <= NIL;
            time_acc <= '0;
          end else begin
            scan <= scan + LW'(1);
          end
        end
        dltq_pkg::ST_WCHK: begin
          cur_delta <= rd_delta;
          if (walk_ok) begin
            time_acc <= walk_sum[DW-1:0];
            prev     <= cur;
            cur      <= rd_link;
          end
        end
        dltq_pkg::ST_INSERT: begin
          busy[slot] <= 1'b1;
          res_kind   <= dltq_pkg::KIND_ACCEPTED;
        end
        dltq_pkg::ST_LINK: begin
          if (prev == NIL) head <= LW'(slot);
        end
        dltq_pkg::ST_TCHK: begin
          if (out_free) begin
            first <= 1'b0;
            if (tk_fire) begin
              pend_cb             <= rd_cb;
              pend_arg            <= rd_arg;
              have_pend           <= 1'b1;
              busy[head[IW-1:0]]  <= 1'b0;
              head                <= rd_link;
              fired_n             <= fired_n + dltq_pkg::FIRED_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.result_kind    <= emit_kind;
      res.fired_callback <= emit_cb;
      res.fired_argument <= emit_arg;
      res.last_of_run    <= emit_last;
    end
  end

endmodule

// ----- bench/tb_delta_list_timer_queue.sv -----
// Self-checking testbench for the delta-list timer queue: predictor, stimulus and result check.
module tb_delta_list_timer_queue;

  localparam int NIL_SLOT = dltq_pkg::SLOTS_DEF;
  localparam longint unsigned DELAY_MAX = (64'd1 << dltq_pkg::DELAY_BITS_DEF) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 110;

  typedef struct {
    dltq_pkg::result_kind_t     kind;
    logic [dltq_pkg::TAG_W-1:0] callback;
    logic [dltq_pkg::TAG_W-1:0] argument;
    logic                       last;
  } timer_result_t;

  class expiry_tracker;
    logic [dltq_pkg::TAG_W-1:0] cb_of[dltq_pkg::SLOTS_DEF];
    logic [dltq_pkg::TAG_W-1:0] arg_of[dltq_pkg::SLOTS_DEF];
    longint unsigned  delta_of[dltq_pkg::SLOTS_DEF];
    int               next_of[dltq_pkg::SLOTS_DEF];
    bit               busy[dltq_pkg::SLOTS_DEF];
    int               head = NIL_SLOT;
    timer_result_t    due[$];
    int errors, checked, accepted, rejected, fired, idle_ticks, max_burst;

    function new();
      for (int i = 0; i < dltq_pkg::SLOTS_DEF; i++) begin
        busy[i] = 1'b0;
        next_of[i] = NIL_SLOT;
        delta_of[i] = 0;
      end
    endfunction

    function void note_request(dltq_pkg::req_type_t rq, logic [dltq_pkg::TAG_W-1:0] cb,
                               logic [dltq_pkg::TAG_W-1:0] arg,
                               logic [dltq_pkg::DELAY_IN_W-1:0] dly);
      int slot, prev, cur, steps, n;
      longint unsigned span, elapsed;
      timer_result_t r;
      if (rq == dltq_pkg::REQ_SCHEDULE) begin
        slot = -1;
        for (int i = 0; i < dltq_pkg::SLOTS_DEF; i++) begin
          if (!busy[i]) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          r = '{kind: dltq_pkg::KIND_REJECTED, callback: '0, argument: '0, last: 1'b1};
          rejected++;
        end else begin
          span = dly;
          if (span > DELAY_MAX) span = DELAY_MAX;
          prev = NIL_SLOT;
          cur = head;
          elapsed = 0;
          steps = 0;
          while (cur != NIL_SLOT && steps < dltq_pkg::SLOTS_DEF &&
                 delta_of[cur] + elapsed <= span) begin
            elapsed += delta_of[cur];
            prev = cur;
            cur = next_of[cur];
            steps++;
          end
          cb_of[slot] = cb;
          arg_of[slot] = arg;
          delta_of[slot] = (span - elapsed) & DELAY_MAX;
          next_of[slot] = cur;
          busy[slot] = 1'b1;
          if (cur != NIL_SLOT) delta_of[cur] = (delta_of[cur] - delta_of[slot]) & DELAY_MAX;
          if (prev == NIL_SLOT) head = slot;
          else next_of[prev] = slot;
          r = '{kind: dltq_pkg::KIND_ACCEPTED, callback: '0, argument: '0, last: 1'b1};
          accepted++;
        end
        due.push_back(r);
      end else begin
        n = 0;
        if (head != NIL_SLOT && delta_of[head] != 0) delta_of[head]--;
        while (n < dltq_pkg::MAX_RESULTS && head != NIL_SLOT && delta_of[head] == 0) begin
          r = '{kind: dltq_pkg::KIND_FIRED, callback: cb_of[head], argument: arg_of[head],
                last: 1'b0};
          due.push_back(r);
          n++;
          busy[head] = 1'b0;
          head = next_of[head];
        end
        if (n == 0) begin
          r = '{kind: dltq_pkg::KIND_IDLE, callback: '0, argument: '0, last: 1'b1};
          due.push_back(r);
          idle_ticks++;
        end else begin
          due[due.size()-1].last = 1'b1;
          fired += n;
          if (n > max_burst) max_burst = n;
        end
      end
    endfunction

    function void check_result(dltq_pkg::result_kind_t kind, logic [dltq_pkg::TAG_W-1:0] cb,
                               logic [dltq_pkg::TAG_W-1:0] arg, logic last);
      timer_result_t want;
      checked++;
      if (due.size() == 0) begin
        $display("%0t: result with nothing due: kind %0d cb %h arg %h last %b",
                 $time, kind, cb, arg, last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (cb !== want.callback) begin
        $display("%0t: fired_callback expected %h actual %h", $time, want.callback, cb);
        errors++;
      end
      if (arg !== want.argument) begin
        $display("%0t: fired_argument expected %h actual %h", $time, want.argument, arg);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  dltq_req_if req();
  dltq_res_if res();

  delta_list_timer_queue u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  expiry_tracker tracker = new();
  bit idling = 1'b1;
  bit hold_off_req = 1'b0;
  bit held_off = 1'b0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[delta_list_timer_queue] ERROR");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready)
        tracker.check_result(res.result_kind, res.fired_callback, res.fired_argument,
                             res.last_of_run);
      if (stall > 0) begin
        stall--;
        res.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        held_off = 1'b1;
        stall = HOLD_CYCLES - 1;
        res.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 8);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic send(dltq_pkg::req_type_t rq, logic [dltq_pkg::TAG_W-1:0] cb,
                      logic [dltq_pkg::TAG_W-1:0] arg,
                      logic [dltq_pkg::DELAY_IN_W-1:0] dly);
    if (idling && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= rq;
    req.callback_tag <= cb;
    req.argument_tag <= arg;
    req.delay_ticks <= dly;
    do @(posedge clk); while (!req.ready);
    tracker.note_request(rq, cb, arg, dly);
  endtask

  task automatic send_random_schedule();
    int p;
    logic [dltq_pkg::DELAY_IN_W-1:0] dly;
    p = $urandom_range(0, 99);
    if (p < 65) dly = 16'($urandom_range(0, 6));
    else if (p < 94) dly = 16'($urandom_range(7, 40));
    else dly = 16'($urandom_range(0, 65535));
    send(dltq_pkg::REQ_SCHEDULE, 16'($urandom), 16'($urandom), dly);
  endtask

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.req_type <= dltq_pkg::REQ_SCHEDULE;
    req.callback_tag <= '0;
    req.argument_tag <= '0;
    req.delay_ticks <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list, then fill the pool with zero-delay timers
    send(dltq_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < dltq_pkg::SLOTS_DEF; i++)
      send(dltq_pkg::REQ_SCHEDULE, (i % 2) ? 16'hFFFF ^ 16'(i) : 16'(i),
           (i % 2) ? 16'(i) : 16'hFFFF ^ 16'(i), 16'h0000);
    send(dltq_pkg::REQ_SCHEDULE, 16'hABCD, 16'h1234, 16'h0005);
    send(dltq_pkg::REQ_TICK, 16'h0000, 16'h0000, 16'h0000);
    // longest delay, equal expiry times, zero-delay head
    send(dltq_pkg::REQ_SCHEDULE, 16'hFFFF, 16'h0000, 16'hFFFF);
    send(dltq_pkg::REQ_SCHEDULE, 16'h0000, 16'hFFFF, 16'h0002);
    send(dltq_pkg::REQ_SCHEDULE, 16'h5A5A, 16'hA5A5, 16'h0002);
    send(dltq_pkg::REQ_SCHEDULE, 16'hC3C3, 16'h3C3C, 16'h0000);
    repeat (3) send(dltq_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 20) hold_off_req = 1'b1;
      if (k == RANDOM_ITEMS - 30) idling = 1'b0;
      if (k % 40 == 10) begin
        repeat ($urandom_range(3, 6))
          send(dltq_pkg::REQ_SCHEDULE, 16'($urandom), 16'($urandom), 16'h0000);
      end
      if ($urandom_range(0, 99) < 48)
        send(dltq_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
      else send_random_schedule();
    end
    req.valid <= 1'b0;

    while (tracker.due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("schedules: %0d accepted, %0d rejected; %0d timers fired (largest burst %0d)",
             tracker.accepted, tracker.rejected, tracker.fired, tracker.max_burst);
    $display("%0d idle ticks, %0d results checked, long receiver hold-off %0s",
             tracker.idle_ticks, tracker.checked, held_off ? "applied" : "missed");
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("[delta_list_timer_queue] OK");
    end else begin
      $display("[delta_list_timer_queue] ERROR");
    end
    $finish;
  end

endmodule
